// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the limit qualifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define MLSQ_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Clocked assertion on the module's clk and rst_n.
`define MLSQ_ASSERT(lbl, prop, msg) \
  `MLSQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== rtl/mlsq_pkg.sv =====
// Shared types and constants for the motion limit switch qualifier.
`timescale 1ns / 1ps

package mlsq_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned SW_W     = 3;
  localparam int unsigned MODE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CNT_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_DW    = 40;
  localparam int unsigned OUT_DW   = 8;

  // encoder kinds
  localparam logic [KIND_W-1:0] KIND_QUAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABS_LIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABS_ROT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CW_SOFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CCW_SOFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CW_MODE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CCW_MODE = 3'd7;

  // switch mode field
  localparam logic [6:0] MODE_BREAKS = 7'd1;
  localparam logic [6:0] MODE_NONE   = 7'd2;
  localparam int unsigned SWAP_BIT   = 7;

  localparam logic [CNT_W-1:0] SETTLE_TICKS = 2'd2;
  localparam logic [CNT_W-1:0] SETTLE_MAX   = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 32'h7FFF_FFFF;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]  encoder_kind;
    logic               encoder_reversed;
    logic [LIMIT_W-1:0] cw_soft_pos;
    logic [LIMIT_W-1:0] ccw_soft_pos;
    logic [LIMIT_W-1:0] abs_high;
    logic [LIMIT_W-1:0] abs_low;
    logic [MODE_W-1:0]  cw_switch_mode;
    logic [MODE_W-1:0]  ccw_switch_mode;
  } cfg_t;

  typedef struct packed {
    logic index_seen;
    logic ccw_soft_hit;
    logic cw_soft_hit;
    logic ccw_hard;
    logic cw_hard;
  } res_t;

endpackage

// ===== rtl/mlsq_cfg_regs.sv =====
// Configuration register file for the limit qualifier.
`timescale 1ns / 1ps

module mlsq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mlsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlsq_pkg::CFG_DW-1:0]    cfg_wdata,
  output mlsq_pkg::cfg_t                 cfg
);

  mlsq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.encoder_kind     <= mlsq_pkg::KIND_QUAD;
      cfg_r.encoder_reversed <= 1'b0;
      cfg_r.cw_soft_pos      <= mlsq_pkg::LIMIT_MAX;
      cfg_r.ccw_soft_pos     <= mlsq_pkg::LIMIT_MIN;
      cfg_r.abs_high         <= mlsq_pkg::LIMIT_MAX;
      cfg_r.abs_low          <= mlsq_pkg::LIMIT_MIN;
      cfg_r.cw_switch_mode   <= '0;
      cfg_r.ccw_switch_mode  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mlsq_pkg::REG_KIND:     cfg_r.encoder_kind     <= cfg_wdata[mlsq_pkg::KIND_W-1:0];
        mlsq_pkg::REG_REVERSED: cfg_r.encoder_reversed <= cfg_wdata[0];
        mlsq_pkg::REG_CW_SOFT:  cfg_r.cw_soft_pos      <= cfg_wdata[mlsq_pkg::LIMIT_W-1:0];
        mlsq_pkg::REG_CCW_SOFT: cfg_r.ccw_soft_pos     <= cfg_wdata[mlsq_pkg::LIMIT_W-1:0];
        mlsq_pkg::REG_ABS_HIGH: cfg_r.abs_high         <= cfg_wdata[mlsq_pkg::LIMIT_W-1:0];
        mlsq_pkg::REG_ABS_LOW:  cfg_r.abs_low          <= cfg_wdata[mlsq_pkg::LIMIT_W-1:0];
        mlsq_pkg::REG_CW_MODE:  cfg_r.cw_switch_mode   <= cfg_wdata[mlsq_pkg::MODE_W-1:0];
        mlsq_pkg::REG_CCW_MODE: cfg_r.ccw_switch_mode  <= cfg_wdata[mlsq_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mlsq_eval.sv =====
// Limit evaluation logic and per-axis switch state.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mlsq_eval (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mlsq_pkg::cfg_t              cfg,
  input  logic                        step,
  input  logic                        irq_seen,
  input  logic [mlsq_pkg::POS_W-1:0]  position,
  input  logic [mlsq_pkg::SW_W-1:0]   switch_bits,
  input  logic                        homing_active,
  output mlsq_pkg::res_t              res
);

  logic                       irq_pending_r, irq_pending_nxt;
  logic [mlsq_pkg::CNT_W-1:0] settle_count_r, settle_count_nxt;
  logic                       cw_flag_r, cw_flag_nxt;
  logic                       ccw_flag_r, ccw_flag_nxt;
  logic                       index_flag_r, index_flag_nxt;

  logic signed [mlsq_pkg::POS_W-1:0] pos_s;
  logic pend;
  logic gt_hi, lt_hi, gt_lo, lt_lo, gt_cws, lt_ccws;
  logic c_raw, cc_raw, c_pol, cc_pol;
  logic [6:0] cw_mode, ccw_mode;
  logic cw_soft_hit, ccw_soft_hit;

  assign pos_s   = $signed(position);
  assign pend    = irq_pending_r | irq_seen;
  assign gt_hi   = pos_s > $signed(cfg.abs_high);
  assign lt_hi   = pos_s < $signed(cfg.abs_high);
  assign gt_lo   = pos_s > $signed(cfg.abs_low);
  assign lt_lo   = pos_s < $signed(cfg.abs_low);
  assign gt_cws  = pos_s > $signed(cfg.cw_soft_pos);
  assign lt_ccws = pos_s < $signed(cfg.ccw_soft_pos);

  assign cw_soft_hit  = cfg.encoder_reversed ? lt_ccws : gt_cws;
  assign ccw_soft_hit = cfg.encoder_reversed ? gt_cws : lt_ccws;

  assign cw_mode  = cfg.cw_switch_mode[6:0];
  assign ccw_mode = cfg.ccw_switch_mode[6:0];

  // switch polarity and ignore rules
  always_comb begin
    c_raw  = switch_bits[1];
    cc_raw = switch_bits[2];
    c_pol  = (cw_mode == mlsq_pkg::MODE_NONE) ? 1'b0 :
             (cw_mode == mlsq_pkg::MODE_BREAKS) ? ~c_raw : c_raw;
    cc_pol = (ccw_mode == mlsq_pkg::MODE_NONE) ? 1'b0 :
             (ccw_mode == mlsq_pkg::MODE_BREAKS) ? ~cc_raw : cc_raw;
  end

  always_comb begin
    irq_pending_nxt  = pend;
    settle_count_nxt = settle_count_r;
    cw_flag_nxt      = cw_flag_r;
    ccw_flag_nxt     = ccw_flag_r;
    index_flag_nxt   = index_flag_r;
    case (cfg.encoder_kind)
      mlsq_pkg::KIND_ABS_LIN: begin
        cw_flag_nxt = gt_hi;
        if (!gt_hi) begin
          ccw_flag_nxt = lt_lo;
        end
      end
      mlsq_pkg::KIND_ABS_ROT: begin
        if (!cfg.cw_switch_mode[mlsq_pkg::SWAP_BIT]) begin
          if (gt_lo && lt_hi) begin
            cw_flag_nxt  = 1'b0;
            ccw_flag_nxt = 1'b0;
          end else if (lt_lo) begin
            cw_flag_nxt = 1'b1;
          end else begin
            ccw_flag_nxt = 1'b1;
          end
        end else begin
          if (lt_lo || gt_hi) begin
            cw_flag_nxt  = 1'b0;
            ccw_flag_nxt = 1'b0;
          end else if (gt_lo) begin
            cw_flag_nxt = 1'b1;
          end else begin
            ccw_flag_nxt = 1'b1;
          end
        end
      end
      default: begin
        // quadrature (unused kind code lands here too)
        if (pend) begin
          if (homing_active) begin
            index_flag_nxt = 1'b1;
          end
          if (settle_count_r >= mlsq_pkg::SETTLE_TICKS) begin
            irq_pending_nxt = 1'b0;
            index_flag_nxt  = switch_bits[0];
            cw_flag_nxt  = cfg.cw_switch_mode[mlsq_pkg::SWAP_BIT] ? cc_pol : c_pol;
            ccw_flag_nxt = cfg.ccw_switch_mode[mlsq_pkg::SWAP_BIT] ? c_pol : cc_pol;
          end
          if (settle_count_r != mlsq_pkg::SETTLE_MAX) begin
            settle_count_nxt = settle_count_r + 1'b1;
          end
        end else begin
          settle_count_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_pending_r  <= 1'b0;
      settle_count_r <= '0;
      cw_flag_r      <= 1'b0;
      ccw_flag_r     <= 1'b0;
      index_flag_r   <= 1'b0;
    end else if (step) begin
      irq_pending_r  <= irq_pending_nxt;
      settle_count_r <= settle_count_nxt;
      cw_flag_r      <= cw_flag_nxt;
      ccw_flag_r     <= ccw_flag_nxt;
      index_flag_r   <= index_flag_nxt;
    end
  end

  assign res.cw_hard      = cw_flag_nxt;
  assign res.ccw_hard     = ccw_flag_nxt;
  assign res.cw_soft_hit  = cw_soft_hit;
  assign res.ccw_soft_hit = ccw_soft_hit;
  assign res.index_seen   = index_flag_nxt;

  `MLSQ_ASSERT(a_state_hold, !step |=> $stable(settle_count_r) && $stable(irq_pending_r), "state moved without a word")
  `MLSQ_ASSERT(a_lin_cw, step && cfg.encoder_kind == mlsq_pkg::KIND_ABS_LIN && gt_hi |=> cw_flag_r, "linear cw limit missed")
  `MLSQ_ASSERT(a_settle_clear, step && cfg.encoder_kind == mlsq_pkg::KIND_QUAD && pend && settle_count_r >= mlsq_pkg::SETTLE_TICKS |=> !irq_pending_r, "settled irq not cleared")

endmodule

// ===== rtl/motion_limit_switch_qualifier_core.sv =====
// Top level of the motion limit switch qualifier.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Usage:
//   in_*   : one word per service tick (irq_seen, position, switch bits, homing).
//   out_*  : one result word per input word (hard, soft and index flags).
//   cfg_*  : register writes, taken whenever cfg_we is high; write only while idle.
// Path: an accepted word waits in the input register; when it advances, its result
//   loads into the output register and out_tvalid rises with that load.
// Throughput: one word per cycle while out_tready is high. The input register
//   hands its word to the evaluation logic and the axis state updates in the
//   same cycle that the result register loads.
// Stall: while out_tready is low the result register holds; one more word may
//   wait in the input register, then in_tready drops.
// Reset: rst_n low (synchronous) empties both registers, clears the axis state
//   and loads the register defaults (quadrature, soft and absolute limits wide
//   open, switches make on contact).

module motion_limit_switch_qualifier_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] irq_seen, [32:1] position, [35:33] switch_bits, [36] homing_active
  input  logic [mlsq_pkg::IN_DW-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] cw_hard, [1] ccw_hard, [2] cw soft hit, [3] ccw soft hit, [4] index_seen
  output logic [mlsq_pkg::OUT_DW-1:0]    out_tdata,
  input  logic                           cfg_we,
  input  logic [mlsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlsq_pkg::CFG_DW-1:0]    cfg_wdata
);

  mlsq_pkg::cfg_t cfg;
  mlsq_pkg::res_t res;

  logic                       s1_valid_r;
  logic [mlsq_pkg::IN_DW-1:0] s1_data_r;
  logic                       out_valid_r;
  mlsq_pkg::res_t             out_res_r;
  logic                       advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  mlsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mlsq_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step          (advance),
    .irq_seen      (s1_data_r[0]),
    .position      (s1_data_r[32:1]),
    .switch_bits   (s1_data_r[35:33]),
    .homing_active (s1_data_r[36]),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mlsq_pkg::OUT_DW - $bits(mlsq_pkg::res_t)){1'b0}}, out_res_r};

  `MLSQ_ASSERT(a_adv_out, advance |=> out_valid_r, "result word lost")
  `MLSQ_ASSERT(a_take_in, in_tvalid && in_tready |=> s1_valid_r, "input word lost")
  `MLSQ_ASSERT(a_no_drop, s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r), "held word dropped")

endmodule
